>>> sv/esc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esc_pkg
// Shared types, constants and helper functions of the scan-style lift
// controller: field widths, floor range, action and direction codes, and
// the command and status types between the controller and the datapath.
// ----------------------------------------------------------------------------
package esc_pkg;

   // Field widths of the pending-call mask and of a floor number.
   localparam int MASK_W  = 8;
   localparam int FLOOR_W = 4;

   // Number of floors served, held to the range that the mask can carry.
   localparam int NUM_FLOORS    = 8;
   localparam int TOP_FLOOR_INT = (NUM_FLOORS < 2) ? 2 : ((NUM_FLOORS > MASK_W) ? MASK_W
                                                                                 : NUM_FLOORS);
   localparam logic [FLOOR_W-1:0] TOP_FLOOR = FLOOR_W'(TOP_FLOOR_INT);
   localparam logic [MASK_W-1:0]  TOP_MASK  = MASK_W'((64'd1 << TOP_FLOOR_INT) - 64'd1);

   // Reset values and the floor codes for no floor and the lowest floor.
   localparam logic [FLOOR_W-1:0] FLOOR_RESET = FLOOR_W'(1);
   localparam logic [FLOOR_W-1:0] HOME_RESET  = FLOOR_W'(5);
   localparam logic [FLOOR_W-1:0] FLOOR_NONE  = FLOOR_W'(0);
   localparam logic [FLOOR_W-1:0] FLOOR_LOW   = FLOOR_W'(1);

   // At most this many home-run floors are travelled within one pass.
   localparam int HOME_RUN_MAX = 4;
   localparam int CNT_W        = $clog2(HOME_RUN_MAX + 1);

   typedef enum logic [1:0] {
      ACT_NONE = 2'd0,
      ACT_UP   = 2'd1,
      ACT_DOWN = 2'd2,
      ACT_DOOR = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      DIR_STOP = 2'd0,
      DIR_UP   = 2'd1,
      DIR_DOWN = 2'd2
   } dir_type;

   // Controller states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_START,
      ST_HOME,
      ST_SCAN,
      ST_MOVE,
      ST_DONE
   } state_type;

   // Datapath operations issued by the controller, one per cycle.
   typedef enum logic [2:0] {
      OP_NONE,
      OP_ACCEPT,
      OP_HOME_START,
      OP_HOME_STEP,
      OP_SCAN,
      OP_MOVE,
      OP_FINISH
   } op_type;

   // Status returned by the datapath to the controller.
   typedef struct packed {
      logic home_go;    // home run is due: request latched, stopped, away from home
      logic home_more;  // lift is not yet at the home floor
      logic out_free;   // output register can take a new result this cycle
   } status_type;

   // One result item, without its last flag.
   typedef struct packed {
      action_type           action;
      logic [FLOOR_W-1:0]   floor_now;
      dir_type              direction;
      logic [FLOOR_W-1:0]   target_floor;
      logic [MASK_W-1:0]    pending_calls;
      logic                 restart;
   } result_type;

   // Mask bit of a floor; floors outside 1..8 have none.
   function automatic logic [MASK_W-1:0] floor_bit(input logic [FLOOR_W-1:0] f);
      logic [MASK_W-1:0] b;
      b = '0;
      if (f >= FLOOR_LOW && f <= FLOOR_W'(MASK_W)) begin
         b = MASK_W'(1) << (f - FLOOR_LOW);
      end
      return b;
   endfunction

endpackage

>>> sv/esc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esc_ctrl
// Sequencer of one control-loop pass: takes the request, runs the home
// steps, the direction scan, the movement step and the closing transfer,
// issuing one datapath operation per cycle.
// ----------------------------------------------------------------------------
module esc_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  esc_pkg::status_type   status,
   output esc_pkg::op_type       op
);

   esc_pkg::state_type             state_ff, state_in;
   logic [esc_pkg::CNT_W-1:0]      cnt_ff, cnt_in;

   // State and home-step counter registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= esc_pkg::ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         esc_pkg::ST_IDLE: begin
            if (req_valid) state_in = esc_pkg::ST_START;
         end
         esc_pkg::ST_START: begin
            state_in = status.home_go ? esc_pkg::ST_HOME : esc_pkg::ST_SCAN;
         end
         esc_pkg::ST_HOME: begin
            if (cnt_ff == esc_pkg::CNT_W'(esc_pkg::HOME_RUN_MAX) || !status.home_more) begin
               state_in = esc_pkg::ST_SCAN;
            end
         end
         esc_pkg::ST_SCAN: begin
            state_in = esc_pkg::ST_MOVE;
         end
         esc_pkg::ST_MOVE: begin
            if (status.out_free) state_in = esc_pkg::ST_DONE;
         end
         esc_pkg::ST_DONE: begin
            if (status.out_free) state_in = esc_pkg::ST_IDLE;
         end
         default: state_in = esc_pkg::ST_IDLE;
      endcase
   end

   // Outputs: the datapath operation, the request stall and the step count.
   always_comb begin
      op        = esc_pkg::OP_NONE;
      req_stall = 1'b1;
      cnt_in    = cnt_ff;
      unique case (state_ff)
         esc_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) op = esc_pkg::OP_ACCEPT;
         end
         esc_pkg::ST_START: begin
            cnt_in = '0;
            if (status.home_go) op = esc_pkg::OP_HOME_START;
         end
         esc_pkg::ST_HOME: begin
            if (cnt_ff != esc_pkg::CNT_W'(esc_pkg::HOME_RUN_MAX) && status.home_more
                && status.out_free) begin
               op     = esc_pkg::OP_HOME_STEP;
               cnt_in = cnt_ff + 1'b1;
            end
         end
         esc_pkg::ST_SCAN: begin
            op = esc_pkg::OP_SCAN;
         end
         esc_pkg::ST_MOVE: begin
            if (status.out_free) op = esc_pkg::OP_MOVE;
         end
         esc_pkg::ST_DONE: begin
            if (status.out_free) op = esc_pkg::OP_FINISH;
         end
         default: op = esc_pkg::OP_NONE;
      endcase
   end

endmodule

>>> sv/esc_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esc_datapath
// Lift state, home-floor register, direction and target scan, single-floor
// movement, a staging register that holds the newest result until it is
// known whether it closes the pass, and the output register.
// ----------------------------------------------------------------------------
module esc_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  esc_pkg::op_type               op,
   output esc_pkg::status_type           status,
   input  logic [3:0]                    req_key_code,
   input  logic                          req_idle_timeout,
   input  logic                          csr_valid,
   input  logic                          csr_ready,
   input  logic [esc_pkg::FLOOR_W-1:0]   csr_home_floor,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [1:0]                    rsp_action,
   output logic [esc_pkg::FLOOR_W-1:0]   rsp_floor_now,
   output logic [1:0]                    rsp_direction,
   output logic [esc_pkg::FLOOR_W-1:0]   rsp_target_floor,
   output logic [esc_pkg::MASK_W-1:0]    rsp_pending_calls,
   output logic                          rsp_restart_idle_timer,
   output logic                          rsp_last
);

   // Lift state.
   logic [esc_pkg::FLOOR_W-1:0] floor_ff, floor_in;
   esc_pkg::dir_type            dir_ff, dir_in;
   logic [esc_pkg::FLOOR_W-1:0] target_ff, target_in;
   logic [esc_pkg::MASK_W-1:0]  mask_ff, mask_in;
   logic                        home_req_ff, home_req_in;
   logic                        restart_ff, restart_in;
   logic [esc_pkg::FLOOR_W-1:0] home_ff;

   // Staging and output registers.
   esc_pkg::result_type         stage_ff, stage_in;
   logic                        stage_valid_ff, stage_valid_in;
   esc_pkg::result_type         out_ff, out_in;
   logic                        out_last_ff, out_last_in;
   logic                        out_valid_ff, out_valid_in;

   // Working signals.
   logic [esc_pkg::FLOOR_W-1:0] home_eff;
   logic [esc_pkg::MASK_W-1:0]  own;
   logic [esc_pkg::MASK_W-1:0]  below_ones;
   logic [esc_pkg::MASK_W-1:0]  below_calls;
   logic [esc_pkg::MASK_W-1:0]  above_calls;
   logic [esc_pkg::FLOOR_W-1:0] cand_down;
   logic [esc_pkg::FLOOR_W-1:0] cand_up;
   logic [esc_pkg::FLOOR_W-1:0] step_floor;
   esc_pkg::dir_type            scan_dir;
   logic                        emit;
   esc_pkg::action_type         emit_action;
   logic                        out_free;

   // Home floor as written, held to the served range.
   always_comb begin
      home_eff = home_ff;
      if (home_ff < esc_pkg::FLOOR_LOW) home_eff = esc_pkg::FLOOR_LOW;
      if (home_ff > esc_pkg::TOP_FLOOR) home_eff = esc_pkg::TOP_FLOOR;
   end

   // Nearest pending floor below and at or above the current floor.
   always_comb begin
      own         = esc_pkg::floor_bit(floor_ff);
      below_ones  = (esc_pkg::MASK_W'(1) << (floor_ff - esc_pkg::FLOOR_LOW))
                    - esc_pkg::MASK_W'(1);
      below_calls = mask_ff & below_ones;
      above_calls = mask_ff & ~below_ones & esc_pkg::TOP_MASK;
      cand_down   = esc_pkg::FLOOR_NONE;
      cand_up     = esc_pkg::FLOOR_NONE;
      for (int i = 0; i < esc_pkg::MASK_W; i++) begin
         if (below_calls[i]) cand_down = esc_pkg::FLOOR_W'(i + 1);
      end
      for (int i = esc_pkg::MASK_W - 1; i >= 0; i--) begin
         if (above_calls[i]) cand_up = esc_pkg::FLOOR_W'(i + 1);
      end
   end

   // A stopped lift with calls picks its direction from the call mask.
   always_comb begin
      scan_dir = dir_ff;
      if (mask_ff != '0 && dir_ff == esc_pkg::DIR_STOP) begin
         if (mask_ff < own) begin
            scan_dir = esc_pkg::DIR_DOWN;
         end else if (mask_ff > own) begin
            scan_dir = esc_pkg::DIR_UP;
         end
      end
   end

   assign out_free = !out_valid_ff || !rsp_stall;

   // Next lift state for the operation of this cycle.
   always_comb begin
      floor_in    = floor_ff;
      dir_in      = dir_ff;
      target_in   = target_ff;
      mask_in     = mask_ff;
      home_req_in = home_req_ff;
      restart_in  = restart_ff;
      emit        = 1'b0;
      emit_action = esc_pkg::ACT_NONE;
      step_floor  = floor_ff;
      unique case (op)
         esc_pkg::OP_ACCEPT: begin
            restart_in = req_key_code != 4'd0;
            if (req_key_code >= esc_pkg::FLOOR_LOW && req_key_code <= esc_pkg::TOP_FLOOR) begin
               mask_in = mask_ff | esc_pkg::floor_bit(req_key_code);
            end
            if (req_idle_timeout) home_req_in = 1'b1;
         end
         esc_pkg::OP_HOME_START: begin
            dir_in      = (floor_ff > home_eff) ? esc_pkg::DIR_DOWN : esc_pkg::DIR_UP;
            home_req_in = 1'b0;
            target_in   = home_eff;
         end
         esc_pkg::OP_HOME_STEP: begin
            emit = 1'b1;
            if (floor_ff > home_eff) begin
               step_floor  = floor_ff - 1'b1;
               emit_action = esc_pkg::ACT_DOWN;
            end else begin
               step_floor  = floor_ff + 1'b1;
               emit_action = esc_pkg::ACT_UP;
            end
            floor_in = step_floor;
            if (step_floor == home_eff) mask_in = mask_ff & ~esc_pkg::floor_bit(home_eff);
         end
         esc_pkg::OP_SCAN: begin
            dir_in = scan_dir;
            if (mask_ff != '0 && scan_dir == esc_pkg::DIR_DOWN) begin
               if (cand_down != esc_pkg::FLOOR_NONE) begin
                  if (target_ff == esc_pkg::FLOOR_NONE || target_ff < cand_down) begin
                     target_in = cand_down;
                  end
               end else begin
                  dir_in    = esc_pkg::DIR_STOP;
                  target_in = esc_pkg::FLOOR_NONE;
               end
            end else if (mask_ff != '0 && scan_dir == esc_pkg::DIR_UP) begin
               if (cand_up != esc_pkg::FLOOR_NONE) begin
                  if (target_ff == esc_pkg::FLOOR_NONE || target_ff > cand_up) begin
                     target_in = cand_up;
                  end
               end else begin
                  dir_in    = esc_pkg::DIR_STOP;
                  target_in = esc_pkg::FLOOR_NONE;
               end
            end
         end
         esc_pkg::OP_MOVE: begin
            if (target_ff != esc_pkg::FLOOR_NONE) begin
               emit = 1'b1;
               if (target_ff < floor_ff) begin
                  step_floor  = floor_ff - 1'b1;
                  emit_action = esc_pkg::ACT_DOWN;
               end else if (target_ff > floor_ff) begin
                  step_floor  = floor_ff + 1'b1;
                  emit_action = esc_pkg::ACT_UP;
               end else begin
                  target_in   = esc_pkg::FLOOR_NONE;
                  emit_action = esc_pkg::ACT_DOOR;
               end
               floor_in = step_floor;
               mask_in  = mask_ff & ~esc_pkg::floor_bit(step_floor);
            end
         end
         esc_pkg::OP_NONE, esc_pkg::OP_FINISH: begin
         end
         default: begin
         end
      endcase
   end

   // Staging and output: a new result pushes the staged one out as not last;
   // the end of the pass pushes the staged one, or an idle result, as last.
   always_comb begin
      stage_in       = stage_ff;
      stage_valid_in = stage_valid_ff;
      out_in         = out_ff;
      out_last_in    = out_last_ff;
      out_valid_in   = out_valid_ff && rsp_stall;
      if (emit) begin
         stage_in.action        = emit_action;
         stage_in.floor_now     = floor_in;
         stage_in.direction     = dir_in;
         stage_in.target_floor  = target_in;
         stage_in.pending_calls = mask_in;
         stage_in.restart       = restart_ff;
         stage_valid_in         = 1'b1;
         if (stage_valid_ff) begin
            out_in       = stage_ff;
            out_last_in  = 1'b0;
            out_valid_in = 1'b1;
         end
      end else if (op == esc_pkg::OP_FINISH) begin
         stage_valid_in = 1'b0;
         out_last_in    = 1'b1;
         out_valid_in   = 1'b1;
         if (stage_valid_ff) begin
            out_in = stage_ff;
         end else begin
            out_in.action        = esc_pkg::ACT_NONE;
            out_in.floor_now     = floor_ff;
            out_in.direction     = dir_ff;
            out_in.target_floor  = target_ff;
            out_in.pending_calls = mask_ff;
            out_in.restart       = restart_ff;
         end
      end
   end

   // Control and lift-state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         floor_ff       <= esc_pkg::FLOOR_RESET;
         dir_ff         <= esc_pkg::DIR_STOP;
         target_ff      <= esc_pkg::FLOOR_NONE;
         mask_ff        <= '0;
         home_req_ff    <= 1'b0;
         home_ff        <= esc_pkg::HOME_RESET;
         stage_valid_ff <= 1'b0;
         out_valid_ff   <= 1'b0;
      end else begin
         floor_ff       <= floor_in;
         dir_ff         <= dir_in;
         target_ff      <= target_in;
         mask_ff        <= mask_in;
         home_req_ff    <= home_req_in;
         stage_valid_ff <= stage_valid_in;
         out_valid_ff   <= out_valid_in;
         if (csr_valid && csr_ready) home_ff <= csr_home_floor;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      restart_ff  <= restart_in;
      stage_ff    <= stage_in;
      out_ff      <= out_in;
      out_last_ff <= out_last_in;
   end

   assign status.home_go   = home_req_ff && floor_ff != home_eff && dir_ff == esc_pkg::DIR_STOP;
   assign status.home_more = floor_ff != home_eff;
   assign status.out_free  = out_free;

   assign rsp_valid              = out_valid_ff;
   assign rsp_action             = out_ff.action;
   assign rsp_floor_now          = out_ff.floor_now;
   assign rsp_direction          = out_ff.direction;
   assign rsp_target_floor       = out_ff.target_floor;
   assign rsp_pending_calls      = out_ff.pending_calls;
   assign rsp_restart_idle_timer = out_ff.restart;
   assign rsp_last               = out_last_ff;

endmodule

>>> sv/elevator_scan_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// elevator_scan_controller
// Scan-style lift controller: one control-loop pass per request transfer.
// ----------------------------------------------------------------------------
// Usage:
// The req_ channel carries one pass: a key code and an idle-timeout flag.
// Each pass yields one to five rsp_ transfers (movement steps, a door
// opening, or a single idle result); rsp_last marks the final one.
// The csr_ channel writes the home floor; it is always ready and may only
// be written while no pass is in progress.
// A pass without a home run takes the sequencer through the request
// transfer, the home check, the direction scan, the movement step and the
// closing transfer. A pass that starts a home run adds, after the home
// check, one home-run step per floor for H (1 to 4) floors and one more
// step to leave the home run. req_stall is low only while the sequencer
// waits for a request.
// Each result waits in the staging register until the next result or the
// closing transfer pushes it out; the last result appears as the sequencer
// returns to waiting for the next request.
// When the receiver stalls, the result register holds its payload and the
// sequencer waits before producing the next result.
// Synchronous reset puts the lift at floor 1, stopped, with no target or
// calls, and sets the home floor to 5.
// ----------------------------------------------------------------------------
module elevator_scan_controller (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [3:0]                    req_key_code,
   input  logic                          req_idle_timeout,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [esc_pkg::FLOOR_W-1:0]   csr_home_floor,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [1:0]                    rsp_action,
   output logic [esc_pkg::FLOOR_W-1:0]   rsp_floor_now,
   output logic [1:0]                    rsp_direction,
   output logic [esc_pkg::FLOOR_W-1:0]   rsp_target_floor,
   output logic [esc_pkg::MASK_W-1:0]    rsp_pending_calls,
   output logic                          rsp_restart_idle_timer,
   output logic                          rsp_last
);

   esc_pkg::op_type      op;
   esc_pkg::status_type  status;

   // The home-floor register accepts a write in any cycle.
   assign csr_ready = 1'b1;

   esc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .op        (op)
   );

   esc_datapath u_datapath (
      .clock                  (clock),
      .reset                  (reset),
      .op                     (op),
      .status                 (status),
      .req_key_code           (req_key_code),
      .req_idle_timeout       (req_idle_timeout),
      .csr_valid              (csr_valid),
      .csr_ready              (csr_ready),
      .csr_home_floor         (csr_home_floor),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_action             (rsp_action),
      .rsp_floor_now          (rsp_floor_now),
      .rsp_direction          (rsp_direction),
      .rsp_target_floor       (rsp_target_floor),
      .rsp_pending_calls      (rsp_pending_calls),
      .rsp_restart_idle_timer (rsp_restart_idle_timer),
      .rsp_last               (rsp_last)
   );

endmodule

>>> sv/esc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esc_checker
// Port-level checks of the lift controller, bound to the top level.
// ----------------------------------------------------------------------------
module esc_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_stall,
   input  logic                          rsp_valid,
   input  logic                          rsp_stall,
   input  logic [1:0]                    rsp_action,
   input  logic [esc_pkg::FLOOR_W-1:0]   rsp_floor_now,
   input  logic [1:0]                    rsp_direction,
   input  logic [esc_pkg::FLOOR_W-1:0]   rsp_target_floor,
   input  logic [esc_pkg::MASK_W-1:0]    rsp_pending_calls,
   input  logic                          rsp_restart_idle_timer,
   input  logic                          rsp_last
);

   // A stalled result holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_action) && $stable(rsp_floor_now)
                                 && $stable(rsp_direction) && $stable(rsp_target_floor)
                                 && $stable(rsp_pending_calls)
                                 && $stable(rsp_restart_idle_timer) && $stable(rsp_last))
      else $error("result changed while stalled");

   // Once a request transfer completes, the controller is busy with that pass.
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while a pass is in progress");

   // A door opening always leaves the lift without a target.
   a_door_clears_target: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_action == esc_pkg::ACT_DOOR |-> rsp_target_floor == esc_pkg::FLOOR_NONE)
      else $error("door opened with a target still set");

   // The lift is always on a served floor.
   a_floor_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_floor_now >= esc_pkg::FLOOR_LOW && rsp_floor_now <= esc_pkg::TOP_FLOOR)
      else $error("floor outside the served range");

endmodule

bind elevator_scan_controller esc_checker u_esc_checker (.*);
